// File: rtl/core/scm_pkg.sv
// ============================================================================
// scm_pkg
// Shared types and constants of the scope trigger column mapper.
// ============================================================================
`default_nettype none

package scm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CODE_W    = 8;
    localparam int RUN_W     = 11;
    localparam int BUDGET_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_16BIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_COLUMNS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LIMIT   = 2'd3;

    localparam logic [RUN_W-1:0]    RST_DISPLAY_COLUMNS = 11'd512;
    localparam logic [BUDGET_W-1:0] RST_TRIGGER_LIMIT   = 8'd200;

    localparam logic [7:0]                 QUIET8_LO    = 8'd120;
    localparam logic [7:0]                 QUIET8_HI    = 8'd136;
    localparam logic signed [SAMPLE_W-1:0] QUIET16_LO   = -16'sd1024;
    localparam logic signed [SAMPLE_W-1:0] QUIET16_HI   = 16'sd1024;
    localparam logic [CODE_W-1:0]          CODE8_OFFSET = 8'd112;
    localparam logic [CODE_W-1:0]          PAD_CODE     = 8'd128;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [2:0] {
        PH_QUIET = 3'b001,
        PH_LOUD  = 3'b010,
        PH_MAP   = 3'b100
    } t_phase;

    typedef struct packed {
        logic                trigger_enable;
        logic                sample_16bit;
        logic [RUN_W-1:0]    display_columns;
        logic [BUDGET_W-1:0] trigger_limit;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] level_code;
        logic [RUN_W-1:0]  run_length;
        logic              last_of_window;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

`default_nettype wire

// File: rtl/core/scm_if.sv
// ============================================================================
// scm_if
// Handshake channels of the mapper: sample items, result items, register writes.
// ============================================================================
`default_nettype none

interface scm_in_if;
    import scm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       has_sample;
    logic                       window_end;

    modport source (output valid, output sample_value, output has_sample,
                    output window_end, input ready);
    modport sink   (input valid, input sample_value, input has_sample,
                    input window_end, output ready);
endinterface

interface scm_out_if;
    import scm_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] level_code;
    logic [RUN_W-1:0]  run_length;
    logic              last_of_window;

    modport source (output valid, output level_code, output run_length,
                    output last_of_window, input ready);
    modport sink   (input valid, input level_code, input run_length,
                    input last_of_window, output ready);
endinterface

interface scm_cfg_if;
    import scm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scope_trigger_column_mapper_unit.sv
// ============================================================================
// scope_trigger_column_mapper_unit
// Maps a window of audio samples to oscilloscope column codes after a trigger.
// ============================================================================
//
//   Channel  Dir  Payload                                    Accepted when
//   i_in     in   sample_value, has_sample, window_end       valid && ready
//   o_out    out  level_code, run_length, last_of_window     valid && ready
//   i_cfg    in   index (0..3), data                         valid && ready
//
// An item passes the input register and the mapping logic and is queued in a
// four-entry result buffer, so one item is taken every cycle while the buffer
// has room. The input side stalls while fewer than two buffer entries are free;
// an item giving a sample column and a pad run needs two buffer entries.
// Reset is synchronous; it restores the register defaults and opens a fresh
// window on the next item. Register writes are always accepted.
// ============================================================================
`default_nettype none

module scope_trigger_column_mapper_unit #(
    parameter int MAX_COLUMNS = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    scm_in_if.sink     i_in,
    scm_out_if.source  o_out,
    scm_cfg_if.sink    i_cfg
);
    import scm_pkg::*;

    t_cfg    r_cfg;
    t_push   push;
    logic    space_ok;
    t_result result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_enable  <= 1'b0;
            r_cfg.sample_16bit    <= 1'b0;
            r_cfg.display_columns <= RST_DISPLAY_COLUMNS;
            r_cfg.trigger_limit   <= RST_TRIGGER_LIMIT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TRIGGER_ENABLE:  r_cfg.trigger_enable  <= i_cfg.data[0];
                CFG_SAMPLE_16BIT:    r_cfg.sample_16bit    <= i_cfg.data[0];
                CFG_DISPLAY_COLUMNS: r_cfg.display_columns <= i_cfg.data[RUN_W-1:0];
                CFG_TRIGGER_LIMIT:   r_cfg.trigger_limit   <= i_cfg.data[BUDGET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    scm_mapper #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_mapper (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (i_in.ready),
        .i_sample_value (i_in.sample_value),
        .i_has_sample   (i_in.has_sample),
        .i_window_end   (i_in.window_end),
        .i_space_ok     (space_ok),
        .o_push         (push)
    );

    scm_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (result)
    );

    assign o_out.level_code     = result.level_code;
    assign o_out.run_length     = result.run_length;
    assign o_out.last_of_window = result.last_of_window;

endmodule

`default_nettype wire

// File: rtl/core/scm_classify.sv
// ============================================================================
// scm_classify
// Quiet detection and column code of one sample, for 8-bit and 16-bit formats.
// ============================================================================
`default_nettype none

module scm_classify (
    input  wire logic signed [scm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_sample_16bit,
    output logic                                     o_quiet,
    output logic [scm_pkg::CODE_W-1:0]               o_code
);
    import scm_pkg::*;

    logic [7:0]        byte_val;
    logic signed [4:0] q_floor;
    logic              round_up;
    logic signed [5:0] q_trunc;

    always_comb begin
        byte_val = i_sample[7:0];
        q_floor  = i_sample[15:11];
        round_up = i_sample[15] && (i_sample[10:0] != 11'd0);
        q_trunc  = {q_floor[4], q_floor} + {5'd0, round_up};
        if (i_sample_16bit) begin
            o_quiet = (i_sample > QUIET16_LO) && (i_sample < QUIET16_HI);
            o_code  = PAD_CODE + {{2{q_trunc[5]}}, q_trunc};
        end else begin
            o_quiet = (byte_val > QUIET8_LO) && (byte_val < QUIET8_HI);
            o_code  = {3'd0, byte_val[7:3]} + CODE8_OFFSET;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/scm_mapper.sv
// ============================================================================
// scm_mapper
// Input register, trigger search and column counting; emits up to two results.
// ============================================================================
`default_nettype none

module scm_mapper #(
    parameter int MAX_COLUMNS = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire scm_pkg::t_cfg                       i_cfg,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [scm_pkg::SAMPLE_W-1:0] i_sample_value,
    input  wire logic                                i_has_sample,
    input  wire logic                                i_window_end,
    input  wire logic                                i_space_ok,
    output scm_pkg::t_push                           o_push
);
    import scm_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS + 1);

    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_has;
    logic                       r_wend;

    logic                r_window_open, n_window_open;
    t_phase              r_phase, n_phase;
    logic [BUDGET_W-1:0] r_budget, n_budget;
    logic [CW-1:0]       r_cols, n_cols;

    logic                quiet;
    logic [CODE_W-1:0]   code;
    logic                fire;
    logic [31:0]         cols_ext;
    logic [CW-1:0]       cols_load;
    t_phase              phase_eff;
    logic [BUDGET_W-1:0] budget_eff;
    logic [CW-1:0]       cols_eff;
    logic                map_it;
    logic                emit_col;
    logic                emit_pad;
    logic [CW-1:0]       cols_after;
    logic [31:0]         pad_ext;
    t_result             col_res;
    t_result             pad_res;

    scm_classify u_classify (
        .i_sample       (r_sample),
        .i_sample_16bit (i_cfg.sample_16bit),
        .o_quiet        (quiet),
        .o_code         (code)
    );

    assign fire       = r_in_valid && i_space_ok;
    assign o_in_ready = !r_in_valid || i_space_ok;

    always_comb begin
        cols_ext  = 32'(i_cfg.display_columns);
        cols_load = (cols_ext > 32'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(cols_ext);
        if (r_window_open) begin
            phase_eff  = r_phase;
            budget_eff = r_budget;
            cols_eff   = r_cols;
        end else begin
            phase_eff  = i_cfg.trigger_enable ? PH_QUIET : PH_MAP;
            budget_eff = i_cfg.trigger_limit;
            cols_eff   = cols_load;
        end

        n_phase  = phase_eff;
        n_budget = budget_eff;
        map_it   = 1'b0;
        if (r_has) begin
            unique case (phase_eff)
                PH_QUIET: begin
                    if (budget_eff == '0) begin
                        n_phase = PH_MAP;
                        map_it  = 1'b1;
                    end else begin
                        if (quiet) begin
                            n_phase = PH_LOUD;
                        end
                        n_budget = budget_eff - BUDGET_W'(1);
                    end
                end
                PH_LOUD: begin
                    if ((budget_eff == '0) || !quiet) begin
                        n_phase = PH_MAP;
                        map_it  = 1'b1;
                    end else begin
                        n_budget = budget_eff - BUDGET_W'(1);
                    end
                end
                PH_MAP: begin
                    map_it = 1'b1;
                end
                default: begin
                    map_it = 1'b1;
                end
            endcase
        end

        emit_col   = map_it && (cols_eff != '0);
        cols_after = emit_col ? (cols_eff - CW'(1)) : cols_eff;
        emit_pad   = r_wend && (cols_after != '0);
        n_cols     = emit_pad ? '0 : cols_after;
        n_window_open = !r_wend;

        pad_ext = 32'(cols_after);
        col_res.level_code     = code;
        col_res.run_length     = RUN_W'(1);
        col_res.last_of_window = (cols_after == '0);
        pad_res.level_code     = PAD_CODE;
        pad_res.run_length     = pad_ext[RUN_W-1:0];
        pad_res.last_of_window = 1'b1;

        o_push.res0 = emit_col ? col_res : pad_res;
        o_push.res1 = pad_res;
        if (!fire) begin
            o_push.count = 2'd0;
        end else begin
            o_push.count = {1'b0, emit_col} + {1'b0, emit_pad};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_window_open <= 1'b0;
            r_phase       <= PH_QUIET;
            r_budget      <= RST_TRIGGER_LIMIT;
            r_cols        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_window_open <= n_window_open;
                r_phase       <= n_phase;
                r_budget      <= n_budget;
                r_cols        <= n_cols;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sample <= i_sample_value;
            r_has    <= i_has_sample;
            r_wend   <= i_window_end;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/scm_result_fifo.sv
// ============================================================================
// scm_result_fifo
// Small result queue taking up to two items per cycle and releasing one.
// ============================================================================
`default_nettype none

module scm_result_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire scm_pkg::t_push  i_push,
    output logic                 o_space_ok,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output scm_pkg::t_result     o_result
);
    import scm_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;

    always_comb begin
        o_space_ok  = r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
        o_valid     = r_count != '0;
        o_result    = r_mem[r_rd_ptr];
        pop         = o_valid && i_ready;
        wr_ptr_next = r_wr_ptr + FIFO_PTR_W'(1);
        n_wr_ptr    = r_wr_ptr + FIFO_PTR_W'(i_push.count);
        n_rd_ptr    = pop ? (r_rd_ptr + FIFO_PTR_W'(1)) : r_rd_ptr;
        n_count     = r_count + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.res1;
        end
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ============================================================================
// testbench
// Self-checking testbench of the scope trigger column mapper. A directed part
// covers sample extremes, both sample formats, the trigger search paths and
// the column count corner cases; a random part follows with windows of
// trigger-shaped sample sequences under changing register settings. Every
// accepted result is compared against an independent prediction, with random
// stalls on both handshake sides.
// ============================================================================
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scm_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int COLUMN_CAP   = 1024;

    typedef enum int {
        KIND_QUIET,
        KIND_LOUD,
        KIND_ANY,
        KIND_EDGE
    } t_kind;

    logic i_clk;
    logic i_rst_n;

    scm_in_if  in_if();
    scm_out_if out_if();
    scm_cfg_if cfg_if();

    scope_trigger_column_mapper_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predicted registers and window state of the mapper.
    logic                pred_trigger_enable;
    logic                pred_sample_16bit;
    logic [RUN_W-1:0]    pred_display_columns;
    logic [BUDGET_W-1:0] pred_trigger_limit;
    t_phase              pred_phase;
    logic [BUDGET_W-1:0] pred_budget;
    logic [RUN_W-1:0]    pred_columns_left;
    logic                pred_window_open;

    t_result expected_columns[$];
    int      mismatch_count;
    int      useful_items;
    int      stall_cycles;
    logic    steady;

    // Settings as last written, used to shape the stimulus.
    logic    cur_trigger;
    logic    cur_s16;
    int      cur_columns;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic sample_is_quiet(input logic signed [SAMPLE_W-1:0] v);
        if (pred_sample_16bit) begin
            return (v > -1024) && (v < 1024);
        end
        return (v[7:0] > 8'd120) && (v[7:0] < 8'd136);
    endfunction

    function automatic logic [CODE_W-1:0] sample_code(input logic signed [SAMPLE_W-1:0] v);
        int q;
        if (pred_sample_16bit) begin
            q = int'(v) / 2048;
            return CODE_W'(q + 128);
        end
        return {3'b000, v[7:3]} + 8'd112;
    endfunction

    task automatic predict_columns(input logic signed [SAMPLE_W-1:0] v, input logic has,
                                   input logic wend);
        logic    map_it;
        t_result r;
        map_it = 1'b0;
        if (!pred_window_open) begin
            pred_columns_left = (pred_display_columns > COLUMN_CAP) ? RUN_W'(COLUMN_CAP)
                                                                    : pred_display_columns;
            pred_budget       = pred_trigger_limit;
            pred_phase        = pred_trigger_enable ? PH_QUIET : PH_MAP;
            pred_window_open  = 1'b1;
        end
        if (wend || (has && !(pred_phase == PH_MAP && pred_columns_left == 0))) begin
            useful_items++;
        end
        if (has) begin
            case (pred_phase)
                PH_QUIET: begin
                    if (pred_budget == 0) begin
                        pred_phase = PH_MAP;
                        map_it     = 1'b1;
                    end else begin
                        if (sample_is_quiet(v)) begin
                            pred_phase = PH_LOUD;
                        end
                        pred_budget--;
                    end
                end
                PH_LOUD: begin
                    if (pred_budget == 0 || !sample_is_quiet(v)) begin
                        pred_phase = PH_MAP;
                        map_it     = 1'b1;
                    end else begin
                        pred_budget--;
                    end
                end
                default: begin
                    map_it = 1'b1;
                end
            endcase
            if (map_it && pred_columns_left != 0) begin
                pred_columns_left--;
                r.level_code     = sample_code(v);
                r.run_length     = RUN_W'(1);
                r.last_of_window = (pred_columns_left == 0);
                expected_columns.push_back(r);
            end
        end
        if (wend) begin
            if (pred_columns_left != 0) begin
                r.level_code     = PAD_CODE;
                r.run_length     = pred_columns_left;
                r.last_of_window = 1'b1;
                expected_columns.push_back(r);
                pred_columns_left = '0;
            end
            pred_window_open = 1'b0;
        end
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_TRIGGER_ENABLE:  pred_trigger_enable  = data[0];
            CFG_SAMPLE_16BIT:    pred_sample_16bit    = data[0];
            CFG_DISPLAY_COLUMNS: pred_display_columns = data[RUN_W-1:0];
            CFG_TRIGGER_LIMIT:   pred_trigger_limit   = data[BUDGET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_column(input t_result got);
        t_result want;
        if (expected_columns.size() == 0) begin
            $error("unexpected result: level_code %0d run_length %0d last_of_window %0d",
                   got.level_code, got.run_length, got.last_of_window);
            mismatch_count++;
        end else begin
            want = expected_columns.pop_front();
            if (got.level_code !== want.level_code) begin
                $error("level_code: expected %0d, actual %0d", want.level_code, got.level_code);
                mismatch_count++;
            end
            if (got.run_length !== want.run_length) begin
                $error("run_length: expected %0d, actual %0d", want.run_length, got.run_length);
                mismatch_count++;
            end
            if (got.last_of_window !== want.last_of_window) begin
                $error("last_of_window: expected %0d, actual %0d", want.last_of_window,
                       got.last_of_window);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                apply_register(cfg_if.index, cfg_if.data);
            end
            if (in_if.valid && in_if.ready) begin
                predict_columns(in_if.sample_value, in_if.has_sample, in_if.window_end);
            end
            if (out_if.valid && out_if.ready) begin
                check_column('{out_if.level_code, out_if.run_length, out_if.last_of_window});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= steady || ($urandom_range(99) >= 7);
    end

    task automatic send_item(input logic [SAMPLE_W-1:0] v, input logic has, input logic wend);
        while (!steady && $urandom_range(99) < 7) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.sample_value <= v;
        in_if.has_sample   <= has;
        in_if.window_end   <= wend;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_columns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_registers(input logic [CFG_DAT_W-1:0] trig, input logic [CFG_DAT_W-1:0] s16,
                                 input logic [CFG_DAT_W-1:0] cols,
                                 input logic [CFG_DAT_W-1:0] limit);
        wait_drained();
        write_reg(CFG_TRIGGER_ENABLE, trig);
        write_reg(CFG_SAMPLE_16BIT, s16);
        write_reg(CFG_DISPLAY_COLUMNS, cols);
        write_reg(CFG_TRIGGER_LIMIT, limit);
        cur_trigger = trig[0];
        cur_s16     = s16[0];
        cur_columns = (cols > COLUMN_CAP) ? COLUMN_CAP : int'(cols);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_kind kind);
        logic [SAMPLE_W-1:0] v;
        v = SAMPLE_W'($urandom);
        case (kind)
            KIND_QUIET: begin
                if (cur_s16) begin
                    v = SAMPLE_W'($urandom_range(2046)) - 16'd1023;
                end else begin
                    v[7:0] = 8'(121 + $urandom_range(14));
                end
            end
            KIND_LOUD: begin
                if (cur_s16) begin
                    if ($signed(v) > -1024 && $signed(v) < 1024) begin
                        v ^= 16'h0400;
                    end
                end else if (v[7:0] > 8'd120 && v[7:0] < 8'd136) begin
                    v[7:0] ^= 8'h80;
                end
            end
            KIND_EDGE: begin
                case ($urandom_range(5))
                    0: v = cur_s16 ? 16'hfc00 : {v[15:8], 8'd120};
                    1: v = cur_s16 ? 16'hfc01 : {v[15:8], 8'd121};
                    2: v = cur_s16 ? 16'h03ff : {v[15:8], 8'd135};
                    3: v = cur_s16 ? 16'h0400 : {v[15:8], 8'd136};
                    4: v = cur_s16 ? 16'h8000 : {v[15:8], 8'd0};
                    default: v = cur_s16 ? 16'h7fff : {v[15:8], 8'd255};
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_window();
        int    pre;
        int    quiet_run;
        int    body;
        int    total;
        int    i;
        logic  noise;
        logic  flush_end;
        t_kind kind;
        noise     = ($urandom_range(99) < 15);
        pre       = cur_trigger ? $urandom_range(3) : 0;
        quiet_run = cur_trigger ? $urandom_range(4) : 0;
        body      = $urandom_range(((cur_columns < 40) ? cur_columns : 40) + 4);
        total     = pre + quiet_run + body;
        flush_end = ($urandom_range(99) < 30) || (total == 0);
        for (i = 0; i < total; i++) begin
            if (noise) begin
                kind = ($urandom_range(3) == 0) ? KIND_EDGE : KIND_ANY;
            end else if (i < pre) begin
                kind = KIND_LOUD;
            end else if (i < pre + quiet_run) begin
                kind = KIND_QUIET;
            end else begin
                kind = ($urandom_range(9) == 0) ? KIND_EDGE : KIND_ANY;
            end
            send_item(pick_sample(kind), $urandom_range(99) >= 8,
                      !flush_end && (i == total - 1));
        end
        if (flush_end) begin
            send_item(SAMPLE_W'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic random_config();
        logic [CFG_DAT_W-1:0] trig;
        logic [CFG_DAT_W-1:0] s16;
        logic [CFG_DAT_W-1:0] cols;
        logic [CFG_DAT_W-1:0] limit;
        int                   r;
        trig    = CFG_DAT_W'($urandom);
        trig[0] = ($urandom_range(99) < 60);
        s16     = CFG_DAT_W'($urandom);
        r = $urandom_range(99);
        if (r < 8) begin
            cols = '0;
        end else if (r < 78) begin
            cols = CFG_DAT_W'($urandom_range(40, 1));
        end else if (r < 90) begin
            cols = CFG_DAT_W'($urandom_range(1024, 41));
        end else if (r < 95) begin
            cols = CFG_DAT_W'(1024);
        end else begin
            cols = CFG_DAT_W'($urandom_range(2047, 1025));
        end
        limit = CFG_DAT_W'($urandom);
        r = $urandom_range(99);
        if (r < 15) begin
            limit[7:0] = 8'd0;
        end else if (r < 35) begin
            limit[7:0] = 8'd255;
        end else if (r < 70) begin
            limit[7:0] = 8'($urandom_range(12, 1));
        end
        set_registers(trig, s16, cols, limit);
    endtask

    task automatic test_reset_defaults();
        send_item(16'ha500, 1'b1, 1'b0);
        send_item(16'h5aff, 1'b1, 1'b0);
        send_item(16'hff78, 1'b1, 1'b0);
        send_item(16'h0088, 1'b1, 1'b0);
        send_item(16'h0000, 1'b0, 1'b1);
    endtask

    task automatic test_sample_codes_16bit();
        set_registers(11'd0, 11'd1, 11'd1024, 11'd200);
        send_item(16'h8000, 1'b1, 1'b0);
        send_item(16'h7fff, 1'b1, 1'b0);
        send_item(16'hf7ff, 1'b1, 1'b0);
        send_item(16'hf800, 1'b1, 1'b0);
        send_item(16'hffff, 1'b1, 1'b0);
        send_item(16'h07ff, 1'b1, 1'b0);
        send_item(16'h0800, 1'b1, 1'b1);
    endtask

    task automatic test_trigger_search();
        // Quiet then loud found inside the budget; extra samples after the
        // columns are full are dropped and no pad run follows.
        set_registers(11'd1, 11'd0, 11'd2, 11'd5);
        send_item(16'h0000, 1'b1, 1'b0);
        send_item(16'h0080, 1'b1, 1'b0);
        send_item(16'h00c8, 1'b1, 1'b0);
        send_item(16'h00ff, 1'b1, 1'b0);
        send_item(16'h000a, 1'b1, 1'b1);
        // The budget runs out while still looking for a quiet sample.
        set_registers(11'd1, 11'd0, 11'd2, 11'd2);
        send_item(16'h0000, 1'b1, 1'b0);
        send_item(16'h0000, 1'b1, 1'b0);
        send_item(16'h0000, 1'b1, 1'b0);
        send_item(16'h0000, 1'b0, 1'b1);
        set_registers(11'd1, 11'd0, 11'd0, 11'd0);
        send_item(16'h0010, 1'b1, 1'b1);
    endtask

    task automatic test_column_counts();
        set_registers(11'd0, 11'd0, 11'd2047, 11'd255);
        send_item(16'h0000, 1'b0, 1'b1);
        set_registers(11'd0, 11'd0, 11'd1, 11'd255);
        send_item(16'h00ff, 1'b1, 1'b1);
        set_registers(11'd0, 11'd0, 11'd1024, 11'd255);
        send_item(16'h0000, 1'b0, 1'b1);
    endtask

    task automatic test_random_windows();
        int phase_no;
        int windows;
        int w;
        phase_no     = 0;
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            random_config();
            steady  = (phase_no == 3);
            windows = steady ? 14 : $urandom_range(8, 3);
            for (w = 0; w < windows; w++) begin
                random_window();
            end
            steady = 1'b0;
            phase_no++;
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.sample_value  = '0;
        in_if.has_sample    = 1'b0;
        in_if.window_end    = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_TRIGGER_ENABLE;
        cfg_if.data         = '0;
        out_if.ready        = 1'b0;
        steady              = 1'b0;
        mismatch_count      = 0;
        useful_items        = 0;
        stall_cycles        = 0;
        pred_trigger_enable  = 1'b0;
        pred_sample_16bit    = 1'b0;
        pred_display_columns = RST_DISPLAY_COLUMNS;
        pred_trigger_limit   = RST_TRIGGER_LIMIT;
        pred_phase           = PH_MAP;
        pred_budget          = RST_TRIGGER_LIMIT;
        pred_columns_left    = RST_DISPLAY_COLUMNS;
        pred_window_open     = 1'b0;
        cur_trigger          = 1'b0;
        cur_s16              = 1'b0;
        cur_columns          = 512;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_sample_codes_16bit();
        test_trigger_search();
        test_column_counts();
        test_random_windows();

        wait_drained();
        if (mismatch_count == 0 && expected_columns.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
